/* rtl/sgd_pkg.sv */
// Shared types and constants for the swipe gesture detector.
package sgd_pkg;

    localparam int COORD_W    = 16;
    localparam int TIME_W     = 48;
    localparam int THRESH_W   = 16;
    localparam int IDLE_W     = 24;
    localparam int TRAVEL_W   = THRESH_W + 2;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] CMD_CONTACT = 2'd0;
    localparam logic [1:0] CMD_X       = 2'd1;
    localparam logic [1:0] CMD_Y       = 2'd2;

    localparam logic [2:0] GEST_NONE  = 3'd0;
    localparam logic [2:0] GEST_RIGHT = 3'd1;
    localparam logic [2:0] GEST_LEFT  = 3'd2;
    localparam logic [2:0] GEST_DOWN  = 3'd3;
    localparam logic [2:0] GEST_UP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X_SWIPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y_SWIPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP_US = 2'd2;

    localparam logic [THRESH_W-1:0] MIN_X_SWIPE_RST = 16'd100;
    localparam logic [THRESH_W-1:0] MIN_Y_SWIPE_RST = 16'd80;
    localparam logic [IDLE_W-1:0]   IDLE_GAP_US_RST = 24'd200000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] coord;
        logic [TIME_W-1:0]  time_us;
    } sgd_in_t;

    typedef struct packed {
        logic [2:0] gesture;
        logic       clear_queue;
    } sgd_out_t;

endpackage

/* rtl/swipe_gesture_detector_top.sv */
// Swipe gesture detector: touch event tracking, threshold compare and idle-gap clear.
//
// One item is accepted per clock unless a held result (m_ready low) blocks the input
// register. An accepted item sits there; a single add-and-compare stage then updates the
// axis and contact state and loads the result register once it is free or being read.
// The gesture state written by one item is seen by the item that follows it directly.
// Threshold and idle-gap registers are to be written through the cfg port while no item
// is in flight; the block itself does not enforce this.
module swipe_gesture_detector_top #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sgd_pkg::sgd_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sgd_pkg::sgd_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [sgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sgd_pkg::*;

    localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

    logic                        in_valid_reg;
    sgd_in_t                     in_data_reg;
    logic                        out_valid_reg;
    sgd_out_t                    out_data_reg;

    logic [THRESH_W-1:0]         min_x_reg;
    logic [THRESH_W-1:0]         min_y_reg;
    logic [IDLE_W-1:0]           idle_gap_reg;

    logic [COORD_BITS-1:0]       last_x_reg, last_x_next;
    logic [COORD_BITS-1:0]       last_y_reg, last_y_next;
    logic signed [TRAVEL_W-1:0]  travel_x_reg, travel_x_next;
    logic signed [TRAVEL_W-1:0]  travel_y_reg, travel_y_next;
    logic [TW-1:0]               last_contact_reg, last_contact_next;

    logic                        load_out;
    logic                        advance;

    logic [COORD_BITS-1:0]       pos;
    logic [TW-1:0]               now;
    logic                        is_x;
    logic [COORD_BITS-1:0]       prev_pos;
    logic signed [TRAVEL_W-1:0]  cur_travel;
    logic [THRESH_W-1:0]         limit;
    logic [COORD_BITS:0]         move;
    logic signed [TRAVEL_W-1:0]  move_ext;
    logic signed [TRAVEL_W-1:0]  travel_sum;
    logic signed [TRAVEL_W-1:0]  limit_s;
    logic signed [TRAVEL_W-1:0]  neg_limit;
    logic                        pos_hit;
    logic                        neg_hit;
    logic [2:0]                  axis_gesture;
    logic [TW:0]                 gap_sum;
    logic                        gap_hit;
    sgd_out_t                    out_next;

    // Handshake
    assign load_out = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && load_out;
    assign s_ready  = !in_valid_reg || load_out;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Shared axis datapath
    always_comb begin
        pos        = in_data_reg.coord[COORD_BITS-1:0];
        now        = in_data_reg.time_us[TW-1:0];
        is_x       = (in_data_reg.cmd == CMD_X);
        prev_pos   = is_x ? last_x_reg : last_y_reg;
        cur_travel = is_x ? travel_x_reg : travel_y_reg;
        limit      = is_x ? min_x_reg : min_y_reg;
        move       = {1'b0, pos} - {1'b0, prev_pos};
        move_ext   = (prev_pos != '0)
                   ? {{(TRAVEL_W-COORD_BITS-1){move[COORD_BITS]}}, move}
                   : '0;
        travel_sum = cur_travel + move_ext;
        limit_s    = {{(TRAVEL_W-THRESH_W){1'b0}}, limit};
        neg_limit  = -limit_s;
        pos_hit    = travel_sum > limit_s;
        neg_hit    = travel_sum < neg_limit;
        priority if (pos_hit) begin
            axis_gesture = is_x ? GEST_RIGHT : GEST_DOWN;
        end else if (neg_hit) begin
            axis_gesture = is_x ? GEST_LEFT : GEST_UP;
        end else begin
            axis_gesture = GEST_NONE;
        end
        gap_sum = {1'b0, last_contact_reg} + {{(TW+1-IDLE_W){1'b0}}, idle_gap_reg};
        gap_hit = (last_contact_reg != '0) && ({1'b0, now} > gap_sum);
    end

    // Next state and result
    always_comb begin
        last_x_next         = last_x_reg;
        last_y_next         = last_y_reg;
        travel_x_next       = travel_x_reg;
        travel_y_next       = travel_y_reg;
        last_contact_next   = last_contact_reg;
        out_next.gesture    = GEST_NONE;
        out_next.clear_queue = 1'b0;
        unique case (in_data_reg.cmd)
            CMD_CONTACT: begin
                last_contact_next = now;
                if (gap_hit) begin
                    last_x_next          = '0;
                    last_y_next          = '0;
                    travel_x_next        = '0;
                    travel_y_next        = '0;
                    out_next.clear_queue = 1'b1;
                end
            end
            CMD_X: begin
                last_x_next      = pos;
                travel_x_next    = travel_sum;
                out_next.gesture = axis_gesture;
            end
            CMD_Y: begin
                last_y_next      = pos;
                travel_y_next    = travel_sum;
                out_next.gesture = axis_gesture;
            end
            default: begin
            end
        endcase
        if (out_next.gesture != GEST_NONE) begin
            last_x_next          = '0;
            last_y_next          = '0;
            travel_x_next        = '0;
            travel_y_next        = '0;
            out_next.clear_queue = 1'b1;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

    // Gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            travel_x_reg     <= '0;
            travel_y_reg     <= '0;
            last_contact_reg <= '0;
        end else if (advance) begin
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
            travel_x_reg     <= travel_x_next;
            travel_y_reg     <= travel_y_next;
            last_contact_reg <= last_contact_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg    <= MIN_X_SWIPE_RST;
            min_y_reg    <= MIN_Y_SWIPE_RST;
            idle_gap_reg <= IDLE_GAP_US_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_X_SWIPE: min_x_reg    <= cfg_wdata[THRESH_W-1:0];
                REG_MIN_Y_SWIPE: min_y_reg    <= cfg_wdata[THRESH_W-1:0];
                REG_IDLE_GAP_US: idle_gap_reg <= cfg_wdata[IDLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_data_reg.gesture != GEST_NONE) |-> out_data_reg.clear_queue)
        else $error("gesture reported without queue clear");

    a_report_resets_axes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (out_next.gesture != GEST_NONE) |=>
            (travel_x_reg == '0) && (travel_y_reg == '0) &&
            (last_x_reg == '0) && (last_y_reg == '0))
        else $error("axes not cleared after gesture");

    a_travel_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (out_next.gesture == GEST_NONE) && in_data_reg.cmd == CMD_X |=>
            (travel_x_reg <= $signed({{(TRAVEL_W-THRESH_W){1'b0}}, min_x_reg})) &&
            (travel_x_reg >= -$signed({{(TRAVEL_W-THRESH_W){1'b0}}, min_x_reg})))
        else $error("x travel outside threshold without report");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

/* tb/sv/gesture_predictor_pkg.sv */
// Gesture predictor and result checker for the swipe gesture detector testbench.
package gesture_predictor_pkg;

    import sgd_pkg::*;

    class gesture_predictor;

        logic [THRESH_W-1:0]        min_x;
        logic [THRESH_W-1:0]        min_y;
        logic [IDLE_W-1:0]          idle_gap;
        logic [COORD_W-1:0]         last_x;
        logic [COORD_W-1:0]         last_y;
        logic signed [TRAVEL_W-1:0] travel_x;
        logic signed [TRAVEL_W-1:0] travel_y;
        logic [TIME_W-1:0]          last_contact;
        sgd_out_t                   expected_gestures[$];
        int                         errors;
        int                         checked;

        function new();
            min_x        = MIN_X_SWIPE_RST;
            min_y        = MIN_Y_SWIPE_RST;
            idle_gap     = IDLE_GAP_US_RST;
            last_contact = '0;
            errors       = 0;
            checked      = 0;
            clear_axes();
        endfunction

        function void clear_axes();
            last_x   = '0;
            last_y   = '0;
            travel_x = '0;
            travel_y = '0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_X_SWIPE: min_x = data[THRESH_W-1:0];
                REG_MIN_Y_SWIPE: min_y = data[THRESH_W-1:0];
                REG_IDLE_GAP_US: idle_gap = data[IDLE_W-1:0];
                default: ;
            endcase
        endfunction

        function void step_axis(input logic [COORD_W-1:0] pos,
                                inout logic [COORD_W-1:0] last,
                                inout logic signed [TRAVEL_W-1:0] travel,
                                input logic [THRESH_W-1:0] lim,
                                input logic [2:0] pos_code,
                                input logic [2:0] neg_code,
                                output logic [2:0] gest);
            int sum;
            sum = travel;
            if (last != 0)
                sum = sum + int'(pos) - int'(last);
            last   = pos;
            travel = sum[TRAVEL_W-1:0];
            gest   = GEST_NONE;
            if (sum > int'(lim))
                gest = pos_code;
            else if (sum < -int'(lim))
                gest = neg_code;
        endfunction

        function void note_event(input sgd_in_t ev);
            sgd_out_t          res;
            logic [TIME_W:0]   deadline;
            res = '0;
            case (ev.cmd)
                CMD_CONTACT: begin
                    deadline = {1'b0, last_contact} + idle_gap;
                    if (last_contact != 0 && {1'b0, ev.time_us} > deadline) begin
                        clear_axes();
                        res.clear_queue = 1'b1;
                    end
                    last_contact = ev.time_us;
                end
                CMD_X: step_axis(ev.coord, last_x, travel_x, min_x, GEST_RIGHT, GEST_LEFT,
                                 res.gesture);
                CMD_Y: step_axis(ev.coord, last_y, travel_y, min_y, GEST_DOWN, GEST_UP,
                                 res.gesture);
                default: ;
            endcase
            if (res.gesture != GEST_NONE) begin
                clear_axes();
                res.clear_queue = 1'b1;
            end
            expected_gestures.push_back(res);
        endfunction

        function int pending();
            return expected_gestures.size();
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at result %0d: %s", checked, what);
        endtask

        task check_gesture(input sgd_out_t got);
            sgd_out_t want;
            checked++;
            if (expected_gestures.size() == 0) begin
                report("result with no item pending");
                return;
            end
            want = expected_gestures.pop_front();
            if (got.gesture !== want.gesture)
                report($sformatf("gesture %0d, expected %0d", got.gesture, want.gesture));
            if (got.clear_queue !== want.clear_queue)
                report($sformatf("clear_queue %b, expected %b", got.clear_queue,
                                 want.clear_queue));
        endtask

    endclass

endpackage

/* tb/sv/swipe_gesture_detector_top_test.sv */
// Testbench top for the swipe gesture detector: directed and random touch events.
module swipe_gesture_detector_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sgd_pkg::*;
    import gesture_predictor_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sgd_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    sgd_out_t              m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gesture_predictor tracker;
    bit               in_idle;
    bit               out_idle;
    int               cycle_count;

    // stroke generator state
    logic [TIME_W-1:0] stamp;
    logic [1:0]        stroke_cmd;
    int                stroke_pos;
    int                stroke_step;
    int                stroke_left;

    swipe_gesture_detector_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("swipe_gesture_detector_top_test NOT OK");
            $finish;
        end
    end

    function automatic sgd_in_t ev(input logic [1:0] cmd, input logic [COORD_W-1:0] coord,
                                   input logic [TIME_W-1:0] t);
        sgd_in_t it;
        it.cmd     = cmd;
        it.coord   = coord;
        it.time_us = t;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            stamp = stamp + $urandom_range(0, tracker.idle_gap);
        else if (pick < 85)
            stamp = stamp + tracker.idle_gap + $urandom_range(1, 1000);
        else if (pick < 93)
            stamp = stamp + tracker.idle_gap;
        else
            stamp = stamp + tracker.idle_gap + 1;
        return stamp;
    endfunction

    task automatic make_item(output sgd_in_t it);
        int pick;
        int lim;
        it.cmd     = 2'($urandom);
        it.coord   = 16'($urandom);
        it.time_us = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return;
        if (stroke_left == 0) begin
            stroke_left = $urandom_range(2, 10);
            stroke_cmd  = $urandom_range(0, 1) ? CMD_X : CMD_Y;
            lim         = (stroke_cmd == CMD_X) ? tracker.min_x : tracker.min_y;
            stroke_pos  = $urandom_range(0, 65535);
            stroke_step = $urandom_range(1, lim / 2 + 2);
            if ($urandom_range(0, 1))
                stroke_step = -stroke_step;
            it.cmd     = CMD_CONTACT;
            it.time_us = next_stamp();
            return;
        end
        stroke_left--;
        if (pick < 25) begin
            it.cmd     = CMD_CONTACT;
            it.time_us = next_stamp();
        end else if (pick < 35) begin
            it.cmd = (stroke_cmd == CMD_X) ? CMD_Y : CMD_X;
            if ($urandom_range(0, 9) == 0)
                it.coord = '0;
        end else begin
            it.cmd     = stroke_cmd;
            stroke_pos = (stroke_pos + stroke_step) & 32'hFFFF;
            it.coord   = ($urandom_range(0, 19) == 0) ? '0 : 16'(stroke_pos);
        end
    endtask

    task automatic send_item(input sgd_in_t it);
        int gap;
        gap = in_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_event(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        tracker.write_reg(idx, d);
    endtask

    task automatic apply_settings(input logic [THRESH_W-1:0] mx, input logic [THRESH_W-1:0] my,
                                  input logic [IDLE_W-1:0] gap);
        write_cfg(REG_MIN_X_SWIPE, {8'($urandom), mx});
        write_cfg(REG_MIN_Y_SWIPE, {8'($urandom), my});
        write_cfg(REG_IDLE_GAP_US, gap);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_side
        int wait_cycles;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            wait_cycles = out_idle ? $urandom_range(0, 3) : 0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            tracker.check_gesture(m_data);
        end
    end

    initial begin : stimulus
        sgd_in_t it;
        int      phase;
        tracker     = new();
        cycle_count = 0;
        in_idle     = 1'b1;
        out_idle    = 1'b1;
        stamp       = 48'd1000;
        stroke_left = 0;
        stroke_cmd  = CMD_X;
        stroke_pos  = 0;
        stroke_step = 1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset thresholds: x 100, y 80, idle 200000
        send_item(ev(CMD_CONTACT, 16'h0000, 48'd0));
        send_item(ev(CMD_CONTACT, 16'hFFFF, 48'd5));
        send_item(ev(CMD_X, 16'd1000, '1));
        send_item(ev(CMD_X, 16'd1100, '0));
        send_item(ev(CMD_X, 16'd1101, '0));
        send_item(ev(CMD_X, 16'hFFFF, '0));
        send_item(ev(CMD_X, 16'h0000, '0));
        send_item(ev(CMD_Y, 16'd100, '0));
        send_item(ev(CMD_Y, 16'd181, '0));
        send_item(ev(CMD_Y, 16'hFFFF, '0));
        send_item(ev(CMD_Y, 16'd1, '0));
        send_item(ev(CMD_UNUSED, 16'hFFFF, '1));
        send_item(ev(CMD_X, 16'd500, '0));
        send_item(ev(CMD_Y, 16'd900, '0));
        send_item(ev(CMD_CONTACT, 16'd0, 48'd200005));
        send_item(ev(CMD_X, 16'd450, '0));
        send_item(ev(CMD_CONTACT, 16'd0, 48'd400006));
        send_item(ev(CMD_X, 16'd300, '0));
        send_item(ev(CMD_CONTACT, 16'd0, 48'hFFFF_FFFF_FFFF));
        send_item(ev(CMD_CONTACT, 16'd0, 48'd0));
        send_item(ev(CMD_CONTACT, 16'd0, 48'd1));
        send_item(ev(CMD_Y, 16'h8000, '0));
        send_item(ev(CMD_Y, 16'h0000, '0));

        for (phase = 0; phase < 7; phase++) begin
            drain();
            case (phase)
                0: apply_settings(16'd1, 16'd0, 24'd0);
                1: apply_settings(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
                2: apply_settings(16'd0, 16'd1, 24'($urandom_range(1, 5000)));
                3: apply_settings(16'd100, 16'd80, 24'd200000);
                default: apply_settings(16'($urandom_range(1, 400)),
                                        16'($urandom_range(1, 400)),
                                        24'($urandom_range(1, 100000)));
            endcase
            in_idle  = (phase % 3) != 1;
            out_idle = (phase % 3) != 2;
            repeat (100) begin
                make_item(it);
                send_item(it);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0)
            $display("swipe_gesture_detector_top_test OK");
        else
            $display("swipe_gesture_detector_top_test NOT OK");
        $finish;
    end

endmodule
